[hw/rtl/shdt_pkg.sv]
`timescale 1ns / 1ps

package shdt_pkg;

  // delay line element and field widths
  localparam int SPEED_W   = 16;
  localparam int SAMPLE_W  = 17;
  localparam int HEAT_IN_W = 16;
  localparam int HEAT_W    = 32;
  localparam int COUNT_W   = 32;
  localparam int CFG_W     = 16;
  localparam int SHOT_W    = 8;
  localparam int MARGIN_W  = 10;
  localparam int CFG_IDX_W = 2;

  localparam int SHDT_WINDOW = 8;

  // heat is kept in thousandths
  localparam int MILLI       = 1000;
  localparam int SHOT_MILLI_W = 18;

  // register reset values
  localparam logic [SHOT_W-1:0]   SHOT_HEAT_RST = 8'd10;
  localparam logic [CFG_W-1:0]    DROP_THR_RST  = 16'd300;
  localparam logic [CFG_W-1:0]    RISE_THR_RST  = 16'd30;
  localparam logic [MARGIN_W-1:0] MARGIN_RST    = 10'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHOT_HEAT = 2'd0,
    CFG_DROP_THR  = 2'd1,
    CFG_RISE_THR  = 2'd2,
    CFG_MARGIN    = 2'd3
  } cfg_idx_t;

  // |v| of a 17-bit signed sample, saturated to 16 bits
  function automatic logic [SPEED_W-1:0] speed_mag(input logic [SAMPLE_W-1:0] v);
    logic [SAMPLE_W-1:0] neg;
    neg = ~v + 1'b1;
    if (!v[SAMPLE_W-1]) begin
      speed_mag = v[SPEED_W-1:0];
    end else if (neg[SAMPLE_W-1]) begin
      speed_mag = '1;
    end else begin
      speed_mag = neg[SPEED_W-1:0];
    end
  endfunction

endpackage

[hw/rtl/shdt_cell.sv]
`timescale 1ns / 1ps

module shdt_cell
  import shdt_pkg::*;
(
  input  logic               clk,
  input  logic               shift_en,
  input  logic [SPEED_W-1:0] din,
  output logic [SPEED_W-1:0] dout
);

  logic [SPEED_W-1:0] held;

  // one speed magnitude, passed to the neighbor on every shift
  always_ff @(posedge clk) begin
    if (shift_en) begin
      held <= din;
    end
  end

  assign dout = held;

endmodule

[hw/rtl/shdt_line.sv]
`timescale 1ns / 1ps

module shdt_line
  import shdt_pkg::*;
#(
  parameter int WINDOW = SHDT_WINDOW
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               shift_en,
  input  logic [SPEED_W-1:0] din,
  output logic [SPEED_W-1:0] oldest,
  output logic               full
);

  localparam int FILL_W = $clog2(WINDOW + 1);

  logic [SPEED_W-1:0] tap [WINDOW];
  logic [FILL_W-1:0]  fill;

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        shdt_cell u_cell (
          .clk     (clk),
          .shift_en(shift_en),
          .din     (din),
          .dout    (tap[gi])
        );
      end else begin : g_body
        shdt_cell u_cell (
          .clk     (clk),
          .shift_en(shift_en),
          .din     (tap[gi-1]),
          .dout    (tap[gi])
        );
      end
    end
  endgenerate

  // count of held samples, saturates at the window length
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (shift_en && !full) begin
      fill <= fill + 1'b1;
    end
  end

  assign full   = (fill == FILL_W'(WINDOW));
  assign oldest = tap[WINDOW-1];

endmodule

[hw/rtl/shot_detect_heat_tracker_core.sv]
`timescale 1ns / 1ps

// an accepted input beat is registered in the input stage, then its result beat in the update stage
// throughput: one beat per cycle while the output is not stalled; the heat, arming and count update is combinational
// a full output register holds back the update stage, the input stage still takes one beat
// reset (rst, synchronous): registers return to their defaults, heat, count, arming and
// the fill count of the speed line clear, both stages empty

module shot_detect_heat_tracker_core
  import shdt_pkg::*;
#(
  parameter int WINDOW = SHDT_WINDOW
) (
  input  logic                 clk,
  input  logic                 rst,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // s_tdata: speed_sample[16:0], referee_heat[32:17], cooling_limit[48:33],
  // cooling_rate[64:49], zero pad [71:65]
  input  logic [71:0]          s_tdata,
  // output stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // m_tdata: heat_milli[31:0], shots_total[63:32]
  output logic [63:0]          m_tdata,
  // m_tuser: shot_now
  output logic                 m_tuser,
  // register writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // thresholds are held already scaled by the window length
  localparam int LIM_W = CFG_W + $clog2(WINDOW + 1);
  localparam int CMP_W = LIM_W + 1;

  // ---------------- registers ----------------
  // shot heat is kept only in thousandths
  logic [SHOT_MILLI_W-1:0] shot_milli;
  logic [LIM_W-1:0]        drop_lim;
  logic [LIM_W-1:0]        rise_lim;
  logic [MARGIN_W-1:0]     margin;

  always_ff @(posedge clk) begin
    if (rst) begin
      shot_milli <= SHOT_MILLI_W'(SHOT_HEAT_RST) * SHOT_MILLI_W'(MILLI);
      drop_lim   <= LIM_W'(DROP_THR_RST) * LIM_W'(WINDOW);
      rise_lim   <= LIM_W'(RISE_THR_RST) * LIM_W'(WINDOW);
      margin     <= MARGIN_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SHOT_HEAT: begin
          shot_milli <= SHOT_MILLI_W'(cfg_data[SHOT_W-1:0]) * SHOT_MILLI_W'(MILLI);
        end
        CFG_DROP_THR: drop_lim <= LIM_W'(cfg_data) * LIM_W'(WINDOW);
        CFG_RISE_THR: rise_lim <= LIM_W'(cfg_data) * LIM_W'(WINDOW);
        CFG_MARGIN:   margin   <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- input stage ----------------
  // per-beat work that needs no state: magnitude, referee heat in thousandths,
  // and the override test (referee heat - limit >= margin, done unsigned)
  logic [SAMPLE_W-1:0]  in_speed;
  logic [HEAT_IN_W-1:0] in_ref;
  logic [HEAT_IN_W-1:0] in_limit;
  logic [HEAT_IN_W-1:0] in_cool;

  assign in_speed = s_tdata[16:0];
  assign in_ref   = s_tdata[32:17];
  assign in_limit = s_tdata[48:33];
  assign in_cool  = s_tdata[64:49];

  logic                 s1_valid;
  logic [SPEED_W-1:0]   s1_mag;
  logic [HEAT_W-1:0]    s1_ref_milli;
  logic                 s1_override;
  logic [HEAT_IN_W-1:0] s1_cool;

  logic advance;   // update stage may fire (output slot free or draining)
  logic fire;      // update stage consumes the input stage this cycle
  logic take;      // input beat accepted

  assign advance  = !m_tvalid || m_tready;
  assign fire     = s1_valid && advance;
  assign s_tready = !s1_valid || advance;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_mag       <= speed_mag(in_speed);
      s1_ref_milli <= HEAT_W'(in_ref) * HEAT_W'(MILLI);
      s1_override  <= ({1'b0, in_ref} >=
                       (HEAT_IN_W + 1)'(in_limit) + (HEAT_IN_W + 1)'(margin));
      s1_cool      <= in_cool;
    end
  end

  // ---------------- speed delay line ----------------
  logic [SPEED_W-1:0] line_oldest;   // sample from WINDOW beats back
  logic               line_full;

  shdt_line #(
    .WINDOW(WINDOW)
  ) u_line (
    .clk     (clk),
    .rst     (rst),
    .shift_en(fire),
    .din     (s1_mag),
    .oldest  (line_oldest),
    .full    (line_full)
  );

  // ---------------- update stage ----------------
  logic [HEAT_W-1:0]  heat_acc;
  logic [COUNT_W-1:0] shot_counter;
  logic               drop_armed;
  logic               shot_now;

  logic [HEAT_W-1:0]  heat_cool;
  logic [HEAT_W-1:0]  heat_base;
  logic [HEAT_W:0]    heat_sum;
  logic [HEAT_W-1:0]  heat_next;
  logic [CMP_W-1:0]   new_ext;
  logic [CMP_W-1:0]   old_ext;
  logic               drop_hit;
  logic               shot_hit;

  always_comb begin
    // cooling clamps at zero, then the referee may overwrite
    heat_cool = (heat_acc > HEAT_W'(s1_cool)) ? heat_acc - HEAT_W'(s1_cool) : '0;
    heat_base = s1_override ? s1_ref_milli : heat_cool;

    // newest - oldest against the scaled thresholds, written without negatives
    new_ext  = CMP_W'(s1_mag);
    old_ext  = CMP_W'(line_oldest);
    drop_hit = line_full && (old_ext > new_ext + CMP_W'(drop_lim));
    // drop takes precedence when both thresholds are met
    shot_hit = line_full && !drop_hit && drop_armed &&
               (new_ext > old_ext + CMP_W'(rise_lim));

    // shot heat saturates at full scale
    heat_sum  = {1'b0, heat_base} + (HEAT_W + 1)'(shot_milli);
    heat_next = heat_base;
    if (shot_hit) begin
      heat_next = heat_sum[HEAT_W] ? '1 : heat_sum[HEAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heat_acc     <= '0;
      shot_counter <= '0;
      drop_armed   <= 1'b0;
      shot_now     <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (fire) begin
        heat_acc <= heat_next;
        shot_now <= shot_hit;
        if (drop_hit) begin
          drop_armed <= 1'b1;
        end else if (shot_hit) begin
          drop_armed <= 1'b0;
        end
        if (shot_hit) begin
          shot_counter <= shot_counter + 1'b1;
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // the result beat is the state right after its update
  assign m_tdata = {shot_counter, heat_acc};
  assign m_tuser = shot_now;

endmodule
